// File: hw/rtl/swap_block_bitmap_allocator_assert.svh
// Assertion macros for the swap block allocator checker.
// Expects clk and rst_n in the scope of use; no other dependencies.
`ifndef SWAP_BLOCK_BITMAP_ALLOCATOR_ASSERT_SVH
`define SWAP_BLOCK_BITMAP_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define SBBA_CHK_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbba: same-cycle check failed");

// next-cycle implication
`define SBBA_CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbba: next-cycle check failed");

`endif

// File: hw/rtl/sbba_pkg.sv
// Shared constants, types and helpers for the swap block bitmap allocator.
// No dependencies.
package sbba_pkg;

    localparam int MAP_BYTES     = 128;
    localparam int TOTAL_BLOCKS  = 1024;
    localparam int BITS_PER_BYTE = 8;
    localparam int GROUPS        = MAP_BYTES / BITS_PER_BYTE;

    localparam int IDX_W = $clog2(MAP_BYTES);
    localparam int GRP_W = $clog2(GROUPS);
    localparam int BIT_W = 3;
    localparam int BLK_W = 10;
    localparam int CNT_W = 11;
    localparam int OP_W  = 2;

    localparam logic [OP_W-1:0] OP_ALLOCATE = 2'd0;
    localparam logic [OP_W-1:0] OP_MARK     = 2'd1;
    localparam logic [OP_W-1:0] OP_RELEASE  = 2'd2;

    localparam logic [BITS_PER_BYTE-1:0] BYTE_FULL = 8'hFF;
    localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(TOTAL_BLOCKS);

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] byte_idx;
    } scan_result_t;

    // position of the lowest clear bit; zero when the byte is full
    function automatic logic [BIT_W-1:0] first_zero(input logic [BITS_PER_BYTE-1:0] b);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int i = BITS_PER_BYTE - 1; i >= 0; i--)
        begin
            if (!b[i])
            begin
                pos = BIT_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

// File: hw/rtl/swap_block_bitmap_allocator.sv
// Swap block bitmap allocator, first fit; top level with sequencer and free count.
// Uses sbba_pkg, sbba_map_ram, sbba_free_scan.
//
//  channel | dir | tdata                              | tuser
//  s_*     | in  | [9:0] block_number, rest zero      | [1:0] operation
//  m_*     | out | [9:0] granted_block, [20:10] free  | [0] status
//
// Each transfer goes through accept, byte pick and map read, then modify and write back.
// The byte pick uses registered per-group summaries; the map read data is registered.
// One operation is in flight; the input is taken again once the result is registered.
// A stalled result holds the write-back step until m_tready.
// Reset is asynchronous and needs no clearing pass: the map reads as all free.
module swap_block_bitmap_allocator
    import sbba_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [9:0] block_number
    input  logic [1:0]  s_tuser,   // [1:0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [9:0] granted_block, [20:10] free_blocks
    output logic [0:0]  m_tuser    // [0] status
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_WB   = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [OP_W-1:0]  op_reg, op_next;
    logic [BLK_W-1:0] blk_reg, blk_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             fail_reg, fail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             out_valid_reg, out_valid_next;
    logic             status_reg, status_next;
    logic [BLK_W-1:0] granted_reg, granted_next;
    logic [CNT_W-1:0] free_reg, free_next;

    scan_result_t             scan;
    logic [IDX_W-1:0]         rd_addr;
    logic [BITS_PER_BYTE-1:0] rd_data;
    logic                     wr_en;
    logic [BITS_PER_BYTE-1:0] wr_data;
    logic [BIT_W-1:0]         pick_bit;
    logic [BITS_PER_BYTE-1:0] blk_mask;
    logic                     wb_go;

    sbba_map_ram u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (idx_reg),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sbba_free_scan u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .upd_en   (wr_en),
        .upd_idx  (idx_reg),
        .upd_full (wr_data == BYTE_FULL),
        .result   (scan)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, free_reg, granted_reg};
    assign m_tuser  = status_reg;

    assign rd_addr  = (op_reg == OP_ALLOCATE) ? scan.byte_idx : blk_reg[BLK_W-1:BIT_W];
    assign pick_bit = first_zero(rd_data);
    assign blk_mask = BITS_PER_BYTE'(1) << blk_reg[BIT_W-1:0];
    assign wb_go    = (state_reg == ST_WB) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        blk_next       = blk_reg;
        idx_next       = idx_reg;
        fail_next      = fail_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !m_tready;
        status_next    = status_reg;
        granted_next   = granted_reg;
        free_next      = free_reg;
        wr_en          = 1'b0;
        wr_data        = rd_data;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next    = s_tuser;
                    blk_next   = s_tdata[BLK_W-1:0];
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                idx_next   = rd_addr;
                fail_next  = (count_reg == '0) || !scan.found;
                state_next = ST_WB;
            end
            ST_WB:
            begin
                if (wb_go)
                begin
                    out_valid_next = 1'b1;
                    status_next    = 1'b0;
                    granted_next   = '0;
                    case (op_reg)
                        OP_ALLOCATE:
                        begin
                            if (fail_reg)
                            begin
                                status_next = 1'b1;
                            end
                            else
                            begin
                                wr_en        = 1'b1;
                                wr_data      = rd_data | (BITS_PER_BYTE'(1) << pick_bit);
                                count_next   = count_reg - CNT_W'(1);
                                granted_next = {idx_reg, pick_bit};
                            end
                        end
                        OP_MARK:
                        begin
                            wr_en   = 1'b1;
                            wr_data = rd_data | blk_mask;
                            if (count_reg != '0)
                            begin
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        OP_RELEASE:
                        begin
                            wr_en   = 1'b1;
                            wr_data = rd_data & ~blk_mask;
                            if (count_reg < COUNT_MAX)
                            begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        default:
                        begin
                            wr_en = 1'b0;
                        end
                    endcase
                    free_next  = count_next;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= COUNT_MAX;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        blk_reg     <= blk_next;
        idx_reg     <= idx_next;
        fail_reg    <= fail_next;
        status_reg  <= status_next;
        granted_reg <= granted_next;
        free_reg    <= free_next;
    end

endmodule

// File: hw/rtl/sbba_map_ram.sv
// Used-map byte store: one write port, one read port, registered read data.
// Per-entry valid bits make unwritten bytes read as zero after reset. Uses sbba_pkg.
module sbba_map_ram
    import sbba_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     wr_en,
    input  logic [IDX_W-1:0]         wr_addr,
    input  logic [BITS_PER_BYTE-1:0] wr_data,
    input  logic [IDX_W-1:0]         rd_addr,
    output logic [BITS_PER_BYTE-1:0] rd_data
);

    logic [BITS_PER_BYTE-1:0] mem [MAP_BYTES];
    logic [MAP_BYTES-1:0]     valid_reg;
    logic [BITS_PER_BYTE-1:0] rd_data_reg;
    logic                     rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// File: hw/rtl/sbba_free_scan.sv
// Full-byte summary and first-fit byte search for the allocator.
// Two levels: registered per-group not-full flags, then byte within group. Uses sbba_pkg.
module sbba_free_scan
    import sbba_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             upd_en,
    input  logic [IDX_W-1:0] upd_idx,
    input  logic             upd_full,
    output scan_result_t     result
);

    logic [MAP_BYTES-1:0] full_reg;
    logic [GROUPS-1:0]    grp_open_reg;
    logic [GROUPS-1:0]    grp_open_next;
    logic [GRP_W-1:0]     grp_sel;
    logic                 grp_found;
    logic [BITS_PER_BYTE-1:0] grp_bits;

    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            grp_open_next[g] = (full_reg[g*BITS_PER_BYTE +: BITS_PER_BYTE] != BYTE_FULL);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg     <= '0;
            grp_open_reg <= '1;
        end
        else
        begin
            if (upd_en)
            begin
                full_reg[upd_idx] <= upd_full;
            end
            grp_open_reg <= grp_open_next;
        end
    end

    // lowest group with a byte that is not full
    always_comb
    begin
        grp_sel   = '0;
        grp_found = 1'b0;
        for (int g = GROUPS - 1; g >= 0; g--)
        begin
            if (grp_open_reg[g])
            begin
                grp_sel   = GRP_W'(g);
                grp_found = 1'b1;
            end
        end
    end

    assign grp_bits = full_reg[grp_sel*BITS_PER_BYTE +: BITS_PER_BYTE];
    assign result   = '{found: grp_found, byte_idx: {grp_sel, first_zero(grp_bits)}};

endmodule

// File: hw/rtl/sbba_checker.sv
// Port-level checks for swap_block_bitmap_allocator, bound to the top level.
// Uses the macros in swap_block_bitmap_allocator_assert.svh.
`include "swap_block_bitmap_allocator_assert.svh"

module sbba_checker
    import sbba_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // one operation in flight: input closes right after a transfer
    `SBBA_CHK_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)
    // count never goes above the block total
    `SBBA_CHK_SAME(a_count_bound, m_tvalid, m_tdata[20:10] <= COUNT_MAX)
    // failed allocate grants block zero
    `SBBA_CHK_SAME(a_fail_no_grant, m_tvalid && m_tuser[0], m_tdata[9:0] == '0)
    // stalled result holds
    `SBBA_CHK_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind swap_block_bitmap_allocator sbba_checker u_sbba_checker (.*);

// File: tb/tb_swap_block_bitmap_allocator.sv
// Self-checking testbench for swap_block_bitmap_allocator: first-fit grants, mark, release.
// Depends on sbba_pkg and the allocator RTL; holds its own bitmap and free-count predictor.
module tb_swap_block_bitmap_allocator;
    import sbba_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int IDLE_PCT    = 19;
    localparam int QUIET_FROM  = 3000;
    localparam int QUIET_TO    = 5000;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [BLK_W-1:0] blk;
    } alloc_req_t;

    typedef struct packed {
        logic             status;
        logic [BLK_W-1:0] granted;
        logic [CNT_W-1:0] free;
    } alloc_reply_t;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;    // [9:0] block_number
    logic [1:0]  s_tuser  = '0;    // [1:0] operation
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;          // [9:0] granted_block, [20:10] free_blocks
    logic [0:0]  m_tuser;          // [0] status

    alloc_req_t   alloc_requests[$];
    alloc_reply_t expected_replies[$];
    alloc_req_t   next_req;
    alloc_reply_t seen_reply;
    alloc_reply_t want_reply;

    // predictor state
    bit [TOTAL_BLOCKS-1:0] block_taken;
    logic [CNT_W-1:0]      free_tally;

    int cycle_count      = 0;
    int error_count      = 0;
    int accepted_count   = 0;
    int total_items      = 0;
    int grants           = 0;
    int refused_no_count = 0;
    int refused_full_map = 0;
    int marks            = 0;
    int releases         = 0;
    int ignored_codes    = 0;

    swap_block_bitmap_allocator DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // applies one operation to the shadow map and returns the reply it should produce
    function automatic alloc_reply_t bitmap_update(logic [OP_W-1:0] op, logic [BLK_W-1:0] blk);
        alloc_reply_t r;
        int slot;
        r = '0;
        slot = -1;
        accepted_count++;
        case (op)
            OP_ALLOCATE:
            begin
                for (int b = 0; b < TOTAL_BLOCKS && slot < 0; b++)
                begin
                    if (!block_taken[b])
                        slot = b;
                end
                if (free_tally == '0)
                begin
                    r.status = 1'b1;
                    refused_no_count++;
                end
                else if (slot < 0)
                begin
                    r.status = 1'b1;
                    refused_full_map++;
                end
                else
                begin
                    block_taken[slot] = 1'b1;
                    free_tally = free_tally - 1'b1;
                    r.granted = BLK_W'(slot);
                    grants++;
                end
            end
            // block_number never exceeds the map at these widths
            OP_MARK:
            begin
                block_taken[blk] = 1'b1;
                if (free_tally != '0)
                    free_tally = free_tally - 1'b1;
                marks++;
            end
            OP_RELEASE:
            begin
                block_taken[blk] = 1'b0;
                if (free_tally < COUNT_MAX)
                    free_tally = free_tally + 1'b1;
                releases++;
            end
            default:
            begin
                ignored_codes++;
            end
        endcase
        r.free = free_tally;
        return r;
    endfunction

    function automatic bit idle_now();
        return (cycle_count < QUIET_FROM || cycle_count >= QUIET_TO)
            && ($urandom_range(99) < IDLE_PCT);
    endfunction

    task automatic queue_op(logic [OP_W-1:0] op, logic [BLK_W-1:0] blk);
        alloc_requests.push_back('{op: op, blk: blk});
        total_items++;
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // input side: predict on each transfer, then present the next request or idle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= OP_ALLOCATE;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_replies.push_back(bitmap_update(s_tuser, s_tdata[BLK_W-1:0]));
            if (!s_tvalid || s_tready)
            begin
                if (alloc_requests.size() != 0 && !idle_now())
                begin
                    next_req = alloc_requests.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= 16'(next_req.blk);
                    s_tuser  <= next_req.op;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // output side: random back-pressure and field-by-field compare
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                seen_reply = '{status: m_tuser[0], granted: m_tdata[9:0], free: m_tdata[20:10]};
                if (expected_replies.size() == 0)
                begin
                    $error("result transfer with nothing expected: status %0d granted %0d free %0d",
                           seen_reply.status, seen_reply.granted, seen_reply.free);
                    error_count++;
                end
                else
                begin
                    want_reply = expected_replies.pop_front();
                    if (seen_reply.status !== want_reply.status)
                    begin
                        $error("status mismatch: expected %0d, got %0d",
                               want_reply.status, seen_reply.status);
                        error_count++;
                    end
                    if (seen_reply.granted !== want_reply.granted)
                    begin
                        $error("granted_block mismatch: expected %0d, got %0d",
                               want_reply.granted, seen_reply.granted);
                        error_count++;
                    end
                    if (seen_reply.free !== want_reply.free)
                    begin
                        $error("free_blocks mismatch: expected %0d, got %0d",
                               want_reply.free, seen_reply.free);
                        error_count++;
                    end
                end
            end
            m_tready <= !idle_now();
        end
    end

    initial
    begin
        int pick;
        block_taken = '0;
        free_tally  = COUNT_MAX;

        // directed: extremes, saturation, repeats, bit patterns, unused code
        queue_op(OP_UNUSED, 10'h3FF);
        queue_op(OP_RELEASE, 10'h3FF);      // count already at total
        queue_op(OP_ALLOCATE, 10'h3FF);
        queue_op(OP_ALLOCATE, 10'h000);
        queue_op(OP_MARK, 10'h3FF);
        queue_op(OP_MARK, 10'h3FF);         // already used, count still drops
        queue_op(OP_RELEASE, 10'h3FF);
        queue_op(OP_RELEASE, 10'h3FF);      // already free, count still rises
        queue_op(OP_RELEASE, 10'h000);
        queue_op(OP_ALLOCATE, 10'h155);
        queue_op(OP_MARK, 10'h002);
        queue_op(OP_ALLOCATE, 10'h2AA);
        queue_op(OP_RELEASE, 10'h001);
        queue_op(OP_ALLOCATE, 10'h000);     // hole below the front
        queue_op(OP_MARK, 10'h155);
        queue_op(OP_MARK, 10'h2AA);
        queue_op(OP_RELEASE, 10'h155);
        queue_op(OP_RELEASE, 10'h2AA);
        queue_op(OP_RELEASE, 10'h200);      // free block: count now exceeds free bits
        queue_op(OP_UNUSED, 10'h000);
        queue_op(OP_RELEASE, 10'h3FE);

        // fill the whole map; the surplus count leaves refusals on a full map at the end
        repeat (1024)
            queue_op(OP_ALLOCATE, 10'($urandom_range(1023)));

        // drain the count with marks, then refuse on zero count with a free bit left
        queue_op(OP_MARK, 10'd3);
        queue_op(OP_MARK, 10'd4);
        queue_op(OP_ALLOCATE, 10'd0);
        queue_op(OP_MARK, 10'd5);
        queue_op(OP_RELEASE, 10'd7);
        queue_op(OP_MARK, 10'd6);
        queue_op(OP_ALLOCATE, 10'd0);

        // churn around a nearly full map
        repeat (500)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
                queue_op(OP_ALLOCATE, 10'($urandom_range(1023)));
            else if (pick < 70)
                queue_op(OP_RELEASE, 10'($urandom_range(1023)));
            else if (pick < 94)
                queue_op(OP_MARK, 10'($urandom_range(1023)));
            else
                queue_op(OP_UNUSED, 10'($urandom_range(1023)));
        end

        // mostly releases: count climbs back toward saturation
        repeat (300)
        begin
            pick = $urandom_range(99);
            if (pick < 65)
                queue_op(OP_RELEASE, 10'($urandom_range(1023)));
            else if (pick < 85)
                queue_op(OP_ALLOCATE, 10'($urandom_range(1023)));
            else if (pick < 96)
                queue_op(OP_MARK, 10'($urandom_range(1023)));
            else
                queue_op(OP_UNUSED, 10'($urandom_range(1023)));
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_count < total_items || expected_replies.size() != 0)
            @(negedge clk);
        repeat (12) @(negedge clk);

        $display("Covered %0d transfers: %0d grants, %0d marks, %0d releases, %0d unused codes.",
                 accepted_count, grants, marks, releases, ignored_codes);
        $display("Allocate refusals: %0d at zero count, %0d on a full map; %0d errors.",
                 refused_no_count, refused_full_map, error_count);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/sbba_pkg.sv
hw/rtl/sbba_map_ram.sv
hw/rtl/sbba_free_scan.sv
hw/rtl/swap_block_bitmap_allocator.sv
hw/rtl/sbba_checker.sv
tb/tb_swap_block_bitmap_allocator.sv
